FILE: rtl/lkr_pkg.sv
// Shared types, codes and constants for the LRU-K frame replacer.
package lkr_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int FRAME_W    = 8;
  localparam int COUNT_W    = 4;
  localparam int TOTAL_W    = 7;
  localparam int K_W        = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [K_W-1:0]     K_RESET   = 4'd2;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVICT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_HIST  = 2'd1,
    MEM_CACHE = 2'd2
  } mem_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_e;

  // per-frame state that a cell shows to the controller
  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic               mark;
    mem_e               mem;
  } cell_state_t;

  // update broadcast to every cell
  typedef struct packed {
    logic               apply;
    logic               tgt_wr;
    logic               list_wr;
    logic [COUNT_W-1:0] new_cnt;
    logic               new_mark;
    mem_e               new_mem;
    logic               unl_en;
    mem_e               unl_mem;
    logic               push_en;
    mem_e               push_mem;
  } cell_cmd_t;

  // eviction candidate passed along the chain
  typedef struct packed {
    logic valid;
    logic hist;
  } cand_t;

endpackage

FILE: rtl/lkr_cell.sv
// One frame's replacement state plus one stage of the eviction search chain.
module lkr_cell import lkr_pkg::*; #(
  parameter int IW = 4,
  parameter int ID = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_cmd_t     cmd_i,
  input  logic [IW-1:0] cmd_frame_i,
  input  logic [IW-1:0] cmd_pos_i,
  input  cand_t         cand_i,
  input  logic [IW-1:0] cand_pos_i,
  input  logic [IW-1:0] cand_id_i,
  output cand_t         cand_o,
  output logic [IW-1:0] cand_pos_o,
  output logic [IW-1:0] cand_id_o,
  output cell_state_t   state_o,
  output logic [IW-1:0] pos_o
);

  localparam logic [IW-1:0] MyId = IW'(ID);

  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               mark_q, mark_d;
  mem_e               mem_q, mem_d;
  logic [IW-1:0]      pos_q, pos_d;

  cand_t              cand_q, cand_d;
  logic [IW-1:0]      cpos_q, cpos_d;
  logic [IW-1:0]      cid_q, cid_d;

  logic is_me, dec, inc, eligible, is_hist, take;

  always_comb begin
    is_me  = (cmd_frame_i == MyId);
    dec    = cmd_i.unl_en && (mem_q == cmd_i.unl_mem) && (pos_q > cmd_pos_i);
    inc    = cmd_i.push_en && (mem_q == cmd_i.push_mem);
    cnt_d  = cnt_q;
    mark_d = mark_q;
    mem_d  = mem_q;
    pos_d  = pos_q;
    if (cmd_i.apply) begin
      if (is_me) begin
        if (cmd_i.tgt_wr) begin
          cnt_d  = cmd_i.new_cnt;
          mark_d = cmd_i.new_mark;
          if (cmd_i.list_wr) begin
            mem_d = cmd_i.new_mem;
            pos_d = '0;
          end
        end
      end else begin
        // unlink of the target and push to a list front in one step
        pos_d = pos_q - IW'(dec) + IW'(inc);
      end
    end
  end

  // history beats cache; within a list the highest rank is the oldest
  always_comb begin
    is_hist  = (mem_q == MEM_HIST);
    eligible = mark_q && (is_hist || (mem_q == MEM_CACHE));
    take     = eligible && (!cand_i.valid || (is_hist && !cand_i.hist) ||
                            ((is_hist == cand_i.hist) && (pos_q > cand_pos_i)));
    if (take) begin
      cand_d.valid = 1'b1;
      cand_d.hist  = is_hist;
      cpos_d       = pos_q;
      cid_d        = MyId;
    end else begin
      cand_d = cand_i;
      cpos_d = cand_pos_i;
      cid_d  = cand_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mark_q <= 1'b0;
      mem_q  <= MEM_NONE;
      pos_q  <= '0;
      cand_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      mark_q <= mark_d;
      mem_q  <= mem_d;
      pos_q  <= pos_d;
      cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpos_q <= cpos_d;
    cid_q  <= cid_d;
  end

  assign cand_o        = cand_q;
  assign cand_pos_o    = cpos_q;
  assign cand_id_o     = cid_q;
  assign state_o.cnt   = cnt_q;
  assign state_o.mark  = mark_q;
  assign state_o.mem   = mem_q;
  assign pos_o         = pos_q;

endmodule

FILE: rtl/lru_k_frame_replacer.sv
// LRU-K frame replacer: a row of per-frame cells driven by a small controller.
// Access, set and remove: the target's state is read in LOOK and applied in APPLY.
// Evict: the search chain runs through all FRAMES cells, one per cycle, and the controller
//   stays in LOOK until the search is done; a new item is taken only back in IDLE.
// The output register lets a new item enter while a result still waits to be taken.
// Reset clears all frame state, the evictable total and sets the threshold to 2.
module lru_k_frame_replacer import lkr_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic               evictable_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FRAME_W-1:0] victim_o,
  output logic               found_o,
  output logic               bad_frame_o,
  output logic [TOTAL_W-1:0] evictable_count_o,
  input  logic               cfg_we_i,
  input  logic [K_W-1:0]     cfg_wdata_i
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  state_e state_q, state_d;

  logic [K_W-1:0]     k_q;
  logic [TOTAL_W-1:0] tot_q, tot_nx;
  logic [IW-1:0]      step_q;

  op_e                op_q;
  logic               ev_q;
  logic               bad_q;
  logic [IW-1:0]      tgt_id_q;
  logic [COUNT_W-1:0] tgt_cnt_q;
  logic               tgt_mark_q;
  mem_e               tgt_mem_q;
  logic [IW-1:0]      tgt_pos_q;

  logic               out_valid_q;
  logic [FRAME_W-1:0] victim_q;
  logic               found_q;
  logic               bad_out_q;
  logic [TOTAL_W-1:0] count_q;

  logic accept, apply, slot_free, search_done;

  cell_cmd_t          cmd;
  logic [COUNT_W-1:0] cnt_inc;
  logic               res_found;
  logic [FRAME_W-1:0] res_victim;

  cell_state_t        cstate [FRAMES];
  logic [IW-1:0]      cposv  [FRAMES];
  cand_t              cand   [FRAMES+1];
  logic [IW-1:0]      candp  [FRAMES+1];
  logic [IW-1:0]      candi  [FRAMES+1];

  assign cand[0]  = '0;
  assign candp[0] = '0;
  assign candi[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lkr_cell #(
      .IW (IW),
      .ID (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .cmd_frame_i (tgt_id_q),
      .cmd_pos_i   (tgt_pos_q),
      .cand_i      (cand[g]),
      .cand_pos_i  (candp[g]),
      .cand_id_i   (candi[g]),
      .cand_o      (cand[g+1]),
      .cand_pos_o  (candp[g+1]),
      .cand_id_o   (candi[g+1]),
      .state_o     (cstate[g]),
      .pos_o       (cposv[g])
    );
  end

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign search_done = (step_q == IW'(FRAMES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK:  if (op_q != OP_EVICT || search_done) state_d = ST_APPLY;
      ST_APPLY: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    apply      = (state_q == ST_APPLY) && slot_free;
  end

  // update broadcast and result for the captured target
  always_comb begin
    cmd          = '0;
    cmd.apply    = apply;
    cmd.new_cnt  = tgt_cnt_q;
    cmd.new_mark = tgt_mark_q;
    cmd.new_mem  = tgt_mem_q;
    cmd.unl_mem  = tgt_mem_q;
    cmd.push_mem = MEM_NONE;
    tot_nx       = tot_q;
    res_found    = 1'b0;
    res_victim   = '0;
    cnt_inc      = (tgt_cnt_q == COUNT_MAX) ? COUNT_MAX : tgt_cnt_q + 4'd1;
    if (!bad_q) begin
      case (op_q)
        OP_ACCESS: begin
          cmd.tgt_wr  = 1'b1;
          cmd.new_cnt = cnt_inc;
          if (cnt_inc >= k_q) begin
            cmd.list_wr  = 1'b1;
            cmd.new_mem  = MEM_CACHE;
            cmd.unl_en   = (tgt_mem_q != MEM_NONE);
            cmd.push_en  = 1'b1;
            cmd.push_mem = MEM_CACHE;
          end else if (tgt_mem_q != MEM_HIST) begin
            cmd.list_wr  = 1'b1;
            cmd.new_mem  = MEM_HIST;
            cmd.unl_en   = (tgt_mem_q != MEM_NONE);
            cmd.push_en  = 1'b1;
            cmd.push_mem = MEM_HIST;
          end
        end
        OP_SET: begin
          // a frame never accessed keeps its mark
          if (tgt_cnt_q != '0) begin
            cmd.tgt_wr   = 1'b1;
            cmd.new_mark = ev_q;
            if (tgt_mark_q && !ev_q) tot_nx = tot_q - 7'd1;
            else if (!tgt_mark_q && ev_q) tot_nx = tot_q + 7'd1;
          end
        end
        OP_REMOVE, OP_EVICT: begin
          if (tgt_mark_q) begin
            cmd.tgt_wr   = 1'b1;
            cmd.list_wr  = 1'b1;
            cmd.new_cnt  = '0;
            cmd.new_mark = 1'b0;
            cmd.new_mem  = MEM_NONE;
            cmd.unl_en   = (tgt_mem_q != MEM_NONE);
            tot_nx       = tot_q - 7'd1;
            if (op_q == OP_EVICT) begin
              res_found  = 1'b1;
              res_victim = FRAME_W'(tgt_id_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= K_RESET;
      tot_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) k_q <= cfg_wdata_i;
      if (accept) step_q <= '0;
      else if (state_q == ST_LOOK) step_q <= step_q + IW'(1);
      if (apply) begin
        tot_q       <= tot_nx;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(op_i);
      ev_q     <= evictable_i;
      bad_q    <= (op_e'(op_i) != OP_EVICT) && (frame_i >= FRAME_W'(FRAMES));
      tgt_id_q <= frame_i[IW-1:0];
    end
    if (state_q == ST_LOOK) begin
      if (op_q != OP_EVICT) begin
        // out-of-range ids read garbage here; bad_q blocks its use
        tgt_cnt_q  <= cstate[tgt_id_q].cnt;
        tgt_mark_q <= cstate[tgt_id_q].mark;
        tgt_mem_q  <= cstate[tgt_id_q].mem;
        tgt_pos_q  <= cposv[tgt_id_q];
      end else if (search_done) begin
        tgt_id_q   <= candi[FRAMES];
        tgt_cnt_q  <= '0;
        tgt_mark_q <= cand[FRAMES].valid;
        tgt_mem_q  <= cand[FRAMES].hist ? MEM_HIST : MEM_CACHE;
        tgt_pos_q  <= candp[FRAMES];
      end
    end
    if (apply) begin
      victim_q  <= res_victim;
      found_q   <= res_found;
      bad_out_q <= bad_q;
      count_q   <= tot_nx;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign victim_o          = victim_q;
  assign found_o           = found_q;
  assign bad_frame_o       = bad_out_q;
  assign evictable_count_o = count_q;

endmodule

FILE: rtl/lkr_checker.sv
// Port-level assertions for the LRU-K frame replacer, bound to the top level.
module lkr_checker import lkr_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [FRAME_W-1:0] victim_o,
  input logic               found_o,
  input logic               bad_frame_o,
  input logic [TOTAL_W-1:0] evictable_count_o
);

  // one item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after an item was accepted");

  a_found_excl_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && bad_frame_o))
    else $error("found and bad_frame both set");

  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> victim_o == '0)
    else $error("victim nonzero without a found frame");

  a_victim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (victim_o < FRAME_W'(FRAMES)) &&
                    (evictable_count_o <= TOTAL_W'(FRAMES)))
    else $error("victim or evictable count out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(victim_o) &&
                                   $stable(evictable_count_o))
    else $error("stalled result changed");

endmodule

bind lru_k_frame_replacer lkr_checker #(.FRAMES(FRAMES)) u_lkr_checker (.*);
